FILE: design/bpm_pkg.sv
`default_nettype none
package bpm_pkg;

    typedef enum logic [1:0] {
        CMD_FETCH = 2'd0,
        CMD_UNPIN = 2'd1,
        CMD_NEW   = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_LOADED    = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_UNPINNED  = 3'd3,
        ST_ABSENT    = 3'd4,
        ST_FLUSHED   = 3'd5,
        ST_DISK      = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WBACK = 2'd2,
        OP_ZERO  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_NEWW, S_LA, S_LB, S_HIT, S_MISS, S_VS, S_WR, S_WB,
        S_LOAD, S_EXH, S_FA, S_FE, S_FD
    } t_state;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  frame;
        logic [1:0]  disk_op;
        logic [31:0] disk_page_id;
        logic        last;
    } t_res;

endpackage
`default_nettype wire

FILE: design/bpm_if.sv
`default_nettype none
interface bpm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] page_id;
    logic        mark_dirty;
    modport source(output valid, command, page_id, mark_dirty, input ready);
    modport sink(input valid, command, page_id, mark_dirty, output ready);
endinterface

interface bpm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  frame;
    logic [1:0]  disk_op;
    logic [31:0] disk_page_id;
    logic        last;
    modport source(output valid, status, frame, disk_op, disk_page_id, last, input ready);
    modport sink(input valid, status, frame, disk_op, disk_page_id, last, output ready);
endinterface
`default_nettype wire

FILE: design/buffer_pool_lru_frame_manager.sv
`default_nettype none
// Buffer pool frame manager with least-recently-used replacement and pin
// counts. One command beat is taken at a time and the input is not ready
// until every result beat of that command has been loaded into the output
// register. A lookup walks the frames in two steps each (page memory read,
// then compare). A miss on a full pool adds a victim search over every
// frame through the shared rank comparator. A flush walks every frame and
// takes an extra step for each dirty frame to emit its write-back.
// Recency is kept as a rank per frame (zero is most recent), which holds
// the same order as a most-recent-first list. Output stalls only hold the
// sequencer in its emitting state.
module buffer_pool_lru_frame_manager #(
    parameter int POOL_FRAMES  = 32,
    parameter int PAGE_ID_BITS = 32,
    parameter int PIN_BITS     = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bpm_in_if.sink    i_in,
    bpm_out_if.source o_out
);
    import bpm_pkg::*;

    localparam int CW = $clog2(POOL_FRAMES + 1);
    localparam int FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
    localparam logic [CW-1:0] LAST_IDX = CW'(POOL_FRAMES - 1);

    t_state r_state, n_state;

    // Page memory with registered read at the scan index.
    logic [PAGE_ID_BITS-1:0] r_pmem [POOL_FRAMES];
    logic [PAGE_ID_BITS-1:0] r_rd;

    logic                r_valid [POOL_FRAMES];
    logic                r_dirty [POOL_FRAMES];
    logic [PIN_BITS-1:0] r_pins  [POOL_FRAMES];
    logic [CW-1:0]       r_rank  [POOL_FRAMES];
    logic [CW-1:0]       r_in_use;

    t_cmd                    r_cmd;
    logic [PAGE_ID_BITS-1:0] r_pid;
    logic                    r_mark;
    logic [CW-1:0]           r_idx, n_idx;
    logic [FW-1:0]           r_f, n_f;
    logic [FW-1:0]           r_vic, n_vic;
    logic [CW-1:0]           r_best, n_best;
    logic                    r_found, n_found;

    t_res r_res, n_res;
    logic r_ov;

    logic emit, free;
    logic do_touch, do_load, pin_inc, pin_dec, set_dirty, clr_dirty, fill;
    logic [CW-1:0] touch_p;

    logic [63:0] in_ext;
    logic [63:0] pid_ext, rd_ext;
    logic [FW-1:0] ix;
    logic take;

    assign in_ext  = 64'(i_in.page_id);
    assign pid_ext = 64'(r_pid);
    assign rd_ext  = 64'(r_rd);
    assign ix      = r_idx[FW-1:0];
    assign free    = !r_ov || o_out.ready;
    assign take    = (r_pins[ix] == '0) && (!r_found || r_rank[ix] > r_best);
    assign fill    = !r_valid[r_f];

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.status       = r_res.status;
    assign o_out.frame        = r_res.frame;
    assign o_out.disk_op      = r_res.disk_op;
    assign o_out.disk_page_id = r_res.disk_page_id;
    assign o_out.last         = r_res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_f       = r_f;
        n_vic     = r_vic;
        n_best    = r_best;
        n_found   = r_found;
        n_res     = r_res;
        emit      = 1'b0;
        do_touch  = 1'b0;
        do_load   = 1'b0;
        pin_inc   = 1'b0;
        pin_dec   = 1'b0;
        set_dirty = 1'b0;
        clr_dirty = 1'b0;
        touch_p   = r_rank[r_f];
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in.valid) begin
                    case (t_cmd'(i_in.command))
                        CMD_NEW:   n_state = S_NEWW;
                        CMD_FLUSH: n_state = S_FA;
                        default:   n_state = S_LA;
                    endcase
                end
            end
            S_NEWW: begin
                if (free) begin
                    emit    = 1'b1;
                    n_res   = '{ST_DISK, 5'd0, OP_ZERO, pid_ext[31:0], 1'b0};
                    n_state = S_LA;
                end
            end
            S_LA: n_state = S_LB;
            S_LB: begin
                if (r_valid[ix] && r_rd == r_pid) begin
                    n_f     = ix;
                    n_state = S_HIT;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_MISS;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_LA;
                end
            end
            S_HIT: begin
                if (free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd == CMD_UNPIN) begin
                        pin_dec   = 1'b1;
                        set_dirty = r_mark;
                        n_res = '{ST_UNPINNED, 5'(r_f), OP_NONE, pid_ext[31:0], 1'b1};
                    end else begin
                        pin_inc  = 1'b1;
                        do_touch = 1'b1;
                        n_res = '{ST_HIT, 5'(r_f), OP_NONE, pid_ext[31:0], 1'b1};
                    end
                end
            end
            S_MISS: begin
                n_idx   = '0;
                n_found = 1'b0;
                if (r_cmd == CMD_UNPIN) begin
                    if (free) begin
                        emit    = 1'b1;
                        n_res   = '{ST_ABSENT, 5'd0, OP_NONE, pid_ext[31:0], 1'b1};
                        n_state = S_IDLE;
                    end
                end else if (r_in_use < CW'(POOL_FRAMES)) begin
                    n_f     = r_in_use[FW-1:0];
                    n_state = S_LOAD;
                end else begin
                    n_state = S_VS;
                end
            end
            S_VS: begin
                if (take) begin
                    n_found = 1'b1;
                    n_best  = r_rank[ix];
                    n_vic   = ix;
                end
                if (r_idx == LAST_IDX) begin
                    if (!n_found) begin
                        n_state = S_EXH;
                    end else begin
                        n_f = n_vic;
                        if (r_dirty[n_vic]) begin
                            n_idx   = CW'(n_vic);
                            n_state = S_WR;
                        end else begin
                            n_state = S_LOAD;
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WR: n_state = S_WB;
            S_WB: begin
                if (free) begin
                    emit    = 1'b1;
                    n_res   = '{ST_DISK, 5'(r_f), OP_WBACK, rd_ext[31:0], 1'b0};
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (free) begin
                    emit     = 1'b1;
                    do_load  = 1'b1;
                    do_touch = 1'b1;
                    touch_p  = fill ? r_in_use : r_rank[r_f];
                    n_res    = '{ST_LOADED, 5'(r_f), OP_READ, pid_ext[31:0], 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_EXH: begin
                if (free) begin
                    emit    = 1'b1;
                    n_res   = '{ST_EXHAUSTED, 5'd0, OP_NONE, pid_ext[31:0], 1'b1};
                    n_state = S_IDLE;
                end
            end
            S_FA: begin
                if (r_valid[ix] && r_dirty[ix]) begin
                    n_state = S_FE;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_FD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FE: begin
                if (free) begin
                    emit      = 1'b1;
                    clr_dirty = 1'b1;
                    n_res     = '{ST_DISK, 5'(ix), OP_WBACK, rd_ext[31:0], 1'b0};
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_FA;
                    end
                end
            end
            S_FD: begin
                if (free) begin
                    emit    = 1'b1;
                    n_res   = '{ST_FLUSHED, 5'd0, OP_NONE, 32'd0, 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and sequencer registers without reset.
    always_ff @(posedge i_clk) begin
        r_rd    <= r_pmem[ix];
        r_idx   <= n_idx;
        r_f     <= n_f;
        r_vic   <= n_vic;
        r_best  <= n_best;
        r_found <= n_found;
        r_res   <= n_res;
        if (r_state == S_IDLE && i_in.valid) begin
            r_cmd  <= t_cmd'(i_in.command);
            r_pid  <= in_ext[PAGE_ID_BITS-1:0];
            r_mark <= i_in.mark_dirty;
        end
        if (do_load) begin
            r_pmem[r_f] <= r_pid;
        end
        if (do_touch) begin
            for (int j = 0; j < POOL_FRAMES; j++) begin
                if (r_valid[j] && r_rank[j] < touch_p) begin
                    r_rank[j] <= r_rank[j] + 1'b1;
                end
            end
            r_rank[r_f] <= '0;
        end
    end

    // Frame control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_in_use <= '0;
            for (int j = 0; j < POOL_FRAMES; j++) begin
                r_valid[j] <= 1'b0;
                r_dirty[j] <= 1'b0;
                r_pins[j]  <= '0;
            end
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (pin_inc && r_pins[r_f] != PIN_MAX) begin
                r_pins[r_f] <= r_pins[r_f] + 1'b1;
            end
            if (pin_dec && r_pins[r_f] != '0) begin
                r_pins[r_f] <= r_pins[r_f] - 1'b1;
            end
            if (set_dirty) begin
                r_dirty[r_f] <= 1'b1;
            end
            if (clr_dirty) begin
                r_dirty[ix] <= 1'b0;
            end
            if (do_load) begin
                r_valid[r_f] <= 1'b1;
                r_dirty[r_f] <= 1'b0;
                r_pins[r_f]  <= PIN_BITS'(1);
                if (fill) begin
                    r_in_use <= r_in_use + 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/bpm_checker.sv
`default_nettype none
module bpm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [4:0]  frame,
    input wire logic [1:0]  disk_op,
    input wire logic        last
);
    import bpm_pkg::*;

    // A stalled result beat keeps its content.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable({status, frame, disk_op, last}))
        else $error("stalled result beat changed");

    // The block is busy right after it takes a command.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a command beat");

    // Disk requests are never the final beat of a command.
    a_disk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && status == ST_DISK |-> !last && disk_op != OP_NONE)
        else $error("disk request marked last or without operation");

    // A flush completion carries no frame and no operation.
    a_fdone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && status == ST_FLUSHED |-> last && frame == 5'd0 && disk_op == OP_NONE)
        else $error("bad flush completion beat");

endmodule

bind buffer_pool_lru_frame_manager bpm_checker u_bpm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .status    (o_out.status),
    .frame     (o_out.frame),
    .disk_op   (o_out.disk_op),
    .last      (o_out.last)
);
`default_nettype wire
